FILE: rtl/core/fpc_pkg.sv
// fpc_pkg: shared types, constants and the crc-16/modbus byte update
// for the framed packet checker; no dependencies
package fpc_pkg;

    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 16;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int REASON_W   = 3;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 3'd7;
    localparam logic [COUNT_W-1:0] MIN_LEN_CRC = 3'd6;
    localparam logic [COUNT_W-1:0] MIN_LEN_SUM = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CHAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_CHAR   = 2'd2;

    // frame modes
    localparam logic MODE_CRC = 1'b0;
    localparam logic MODE_SUM = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd35;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd42;

    // verdict codes
    localparam logic [REASON_W-1:0] REASON_NONE   = 3'd0;
    localparam logic [REASON_W-1:0] REASON_SHORT  = 3'd1;
    localparam logic [REASON_W-1:0] REASON_HEADER = 3'd2;
    localparam logic [REASON_W-1:0] REASON_TAIL   = 3'd3;
    localparam logic [REASON_W-1:0] REASON_CHECK  = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } fpc_in_t;

    typedef struct packed {
        logic                frame_ok;
        logic [REASON_W-1:0] fail_reason;
    } fpc_out_t;

    // frame state as it stands once the current byte is folded in
    typedef struct packed {
        logic [BYTE_W-1:0]  dly0;
        logic [BYTE_W-1:0]  dly1;
        logic [BYTE_W-1:0]  dly2;
        logic [BYTE_W-1:0]  dly3;
        logic [CRC_W-1:0]   start_bytes;
        logic [CRC_W-1:0]   crc;
        logic [BYTE_W-1:0]  sum;
        logic [COUNT_W-1:0] count;
    } fpc_view_t;

    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/fpc_frame_track.sv
// fpc_frame_track: per-frame state (delay line, start bytes, crc, sum, count)
// depends on fpc_pkg
module fpc_frame_track (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  fpc_pkg::fpc_in_t        beat,
    output fpc_pkg::fpc_view_t      view
);
    import fpc_pkg::*;

    logic [BYTE_W-1:0]  dly_reg [4];
    logic [CRC_W-1:0]   start_reg;
    logic [CRC_W-1:0]   crc_reg;
    logic [BYTE_W-1:0]  sum_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               fold;

    // oldest byte leaves the delay line once four are held
    assign fold = count_reg >= 3'd4;

    always_comb begin
        view.dly0 = beat.byte_in;
        view.dly1 = dly_reg[0];
        view.dly2 = dly_reg[1];
        view.dly3 = dly_reg[2];
        view.crc  = fold ? crc16_byte(crc_reg, dly_reg[3]) : crc_reg;
        view.sum  = fold ? BYTE_W'(sum_reg + dly_reg[3]) : sum_reg;
        view.start_bytes = start_reg;
        if (count_reg == 3'd0) begin
            view.start_bytes = {beat.byte_in, start_reg[BYTE_W-1:0]};
        end else if (count_reg == 3'd1) begin
            view.start_bytes = {start_reg[CRC_W-1:BYTE_W], beat.byte_in};
        end
        view.count = (count_reg < COUNT_MAX) ? COUNT_W'(count_reg + 3'd1) : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dly_reg[0] <= '0;
            dly_reg[1] <= '0;
            dly_reg[2] <= '0;
            dly_reg[3] <= '0;
            start_reg  <= '0;
            crc_reg    <= CRC_INIT;
            sum_reg    <= '0;
            count_reg  <= '0;
        end else if (step) begin
            if (beat.last_byte) begin
                dly_reg[0] <= '0;
                dly_reg[1] <= '0;
                dly_reg[2] <= '0;
                dly_reg[3] <= '0;
                start_reg  <= '0;
                crc_reg    <= CRC_INIT;
                sum_reg    <= '0;
                count_reg  <= '0;
            end else begin
                dly_reg[0] <= view.dly0;
                dly_reg[1] <= view.dly1;
                dly_reg[2] <= view.dly2;
                dly_reg[3] <= view.dly3;
                start_reg  <= view.start_bytes;
                crc_reg    <= view.crc;
                sum_reg    <= view.sum;
                count_reg  <= view.count;
            end
        end
    end

`ifndef SYNTH
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && beat.last_byte |=> count_reg == '0 && crc_reg == CRC_INIT && sum_reg == '0)
        else $error("frame state not cleared after last beat");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !beat.last_byte |=> count_reg >= $past(count_reg) && count_reg != '0)
        else $error("byte count went backwards inside a frame");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(count_reg) && $stable(crc_reg) && $stable(sum_reg))
        else $error("frame state moved without a beat");
`endif

endmodule

FILE: rtl/core/framed_packet_checker_unit.sv
// framed_packet_checker_unit: top level of the framed packet checker
// depends on fpc_pkg and fpc_frame_track
//
// usage:
//   s_ channel carries one received frame byte per beat (byte_in) with
//   last_byte marking the final byte of a frame. m_ channel carries one
//   verdict per frame (frame_ok, fail_reason), given only for the last beat.
//   cfg_wr_en/cfg_index/cfg_wdata write frame_mode, header_char, tail_char;
//   the user must write only while idle (unenforced); indexes past the list are dropped.
// flow:
//   one byte per cycle while no last byte waits for a free result register.
//   a byte sits in the input register while the crc/sum fold, delay shift
//   and verdict are worked out; the verdict goes into the result register
//   behind m_valid. the crc update is one unrolled 8-bit step of the modbus polynomial.
// reset:
//   aresetn low clears both stages, the frame state (crc 0xFFFF) and sets
//   the registers to mode 0, header '#', tail '*'.
// stall:
//   while m_ready is low and a verdict waits, non-last bytes still flow;
//   a last byte waits in the input register, and s_ready drops only then.
module framed_packet_checker_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fpc_pkg::fpc_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fpc_pkg::fpc_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import fpc_pkg::*;

    // configuration registers
    logic              mode_reg;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] tail_reg;

    // input stage
    fpc_in_t  in_reg;
    logic     in_vld_reg;

    // result stage
    fpc_out_t out_reg;
    fpc_out_t out_next;
    logic     out_vld_reg;
    logic     out_vld_next;

    logic      out_free;
    logic      advance;
    fpc_view_t view;
    logic [REASON_W-1:0] reason;
    logic [BYTE_W-1:0]   sum_check;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_CRC;
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_MODE:  mode_reg   <= cfg_wdata[0];
                CFG_HEADER_CHAR: header_reg <= cfg_wdata;
                CFG_TAIL_CHAR:   tail_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // result register can take a verdict this cycle
    assign out_free = !out_vld_reg || m_ready;
    // only a last beat needs a free result slot
    assign advance  = in_vld_reg && (!in_reg.last_byte || out_free);
    assign s_ready  = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    fpc_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .beat    (in_reg),
        .view    (view)
    );

    // checksum of everything before the check byte in sum mode
    assign sum_check = BYTE_W'(view.sum + view.dly3 + view.dly2);

    // verdict, checks in order: length, header, tail, check value
    always_comb begin
        reason = REASON_NONE;
        if (mode_reg == MODE_CRC) begin
            if (view.count < MIN_LEN_CRC) begin
                reason = REASON_SHORT;
            end else if (view.start_bytes[CRC_W-1:BYTE_W] != header_reg ||
                         view.start_bytes[BYTE_W-1:0] != header_reg) begin
                reason = REASON_HEADER;
            end else if (view.dly0 != tail_reg || view.dly1 != tail_reg) begin
                reason = REASON_TAIL;
            end else if (view.crc != {view.dly3, view.dly2}) begin
                reason = REASON_CHECK;
            end
        end else begin
            if (view.count < MIN_LEN_SUM) begin
                reason = REASON_SHORT;
            end else if (view.start_bytes[CRC_W-1:BYTE_W] != header_reg) begin
                reason = REASON_HEADER;
            end else if (view.dly0 != tail_reg) begin
                reason = REASON_TAIL;
            end else if (sum_check != view.dly1) begin
                reason = REASON_CHECK;
            end
        end
        out_next.frame_ok    = (reason == REASON_NONE);
        out_next.fail_reason = reason;
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance && in_reg.last_byte) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_reg.last_byte) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_verdict_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(in_vld_reg && in_reg.last_byte))
        else $error("verdict without a last beat");

    a_ok_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_reg.frame_ok == (out_reg.fail_reason == REASON_NONE))
        else $error("frame_ok disagrees with fail_reason");

    a_reason_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_reg.fail_reason <= REASON_CHECK)
        else $error("fail_reason out of range");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_reg))
        else $error("stalled input stage lost its beat");
`endif

endmodule

FILE: test/tb_framed_packet_checker_unit.sv
// tb_framed_packet_checker_unit: self-checking bench for the framed packet checker,
// predicts every verdict from the accepted byte beats and the register values
// depends on fpc_pkg and framed_packet_checker_unit
module tb_framed_packet_checker_unit;
    import fpc_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int QUIET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for the pressure phase
    localparam int PHASE_BEATS  = 160;

    // register index past the end of the list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // how a generated frame is spoiled, if at all
    typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_TAIL, FLAW_CHECK, FLAW_SHORT, FLAW_NOISE}
        frame_flaw_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    fpc_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    fpc_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    framed_packet_checker_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5;
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
    end

    // beats waiting to be offered, verdicts waiting to come out
    fpc_in_t  pending_beats [$];
    fpc_out_t expected_verdicts [$];

    // register values as the block should hold them
    logic             cfg_mode   = MODE_CRC;
    logic [BYTE_W-1:0] cfg_header = HEADER_RESET;
    logic [BYTE_W-1:0] cfg_tail   = TAIL_RESET;

    // shadow frame state: four-byte window (0 newest), first two bytes,
    // running crc and sum over bytes that left the window, saturating length
    logic [BYTE_W-1:0]  win [4];
    logic [CRC_W-1:0]   lead_pair;
    logic [CRC_W-1:0]   crc_run;
    logic [BYTE_W-1:0]  sum_run;
    logic [COUNT_W-1:0] frame_len;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_go        = 1'b0;
    bit hold_on        = 1'b0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // crc-16/modbus, one byte, lsb first
    function automatic logic [CRC_W-1:0] modbus_fold(input logic [CRC_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = {1'b0, r[CRC_W-1:1]} ^ (r[0] ? 16'hA001 : 16'h0000);
        return r;
    endfunction

    function automatic void clear_tracker();
        foreach (win[i]) win[i] = '0;
        lead_pair = '0;
        crc_run   = CRC_INIT;
        sum_run   = '0;
        frame_len = '0;
    endfunction

    // fold one accepted beat into the shadow state, queue a verdict on the last beat
    task automatic track_frame_byte(input fpc_in_t beat);
        fpc_out_t           verdict;
        logic [COUNT_W-1:0] prior;
        logic [BYTE_W-1:0]  sum_check;
        logic [REASON_W-1:0] why;
        prior = frame_len;
        why   = REASON_NONE;
        // the byte leaving the window joins the crc and sum
        if (prior >= 3'd4) begin
            crc_run = modbus_fold(crc_run, win[3]);
            sum_run = sum_run + win[3];
        end
        if (prior == 3'd0) begin
            lead_pair[15:8] = beat.byte_in;
        end else if (prior == 3'd1) begin
            lead_pair[7:0] = beat.byte_in;
        end
        win[3] = win[2];
        win[2] = win[1];
        win[1] = win[0];
        win[0] = beat.byte_in;
        if (frame_len != COUNT_MAX) frame_len = frame_len + 3'd1;
        if (beat.last_byte) begin
            if (cfg_mode == MODE_CRC) begin
                // H H payload crc_hi crc_lo T T
                if (frame_len < MIN_LEN_CRC) why = REASON_SHORT;
                else if (lead_pair[15:8] != cfg_header || lead_pair[7:0] != cfg_header)
                    why = REASON_HEADER;
                else if (win[0] != cfg_tail || win[1] != cfg_tail) why = REASON_TAIL;
                else if (crc_run != {win[3], win[2]}) why = REASON_CHECK;
            end else begin
                // H payload cs T, cs is the sum of everything before it
                sum_check = sum_run + win[3] + win[2];
                if (frame_len < MIN_LEN_SUM) why = REASON_SHORT;
                else if (lead_pair[15:8] != cfg_header) why = REASON_HEADER;
                else if (win[0] != cfg_tail) why = REASON_TAIL;
                else if (sum_check != win[1]) why = REASON_CHECK;
            end
            verdict.frame_ok    = (why == REASON_NONE);
            verdict.fail_reason = why;
            expected_verdicts.push_back(verdict);
            clear_tracker();
        end
    endtask

    // build one frame for the current registers; len is the payload length for
    // framed cases and the whole length for short and noise frames
    task automatic queue_frame(input frame_flaw_t flaw, input int len);
        logic [BYTE_W-1:0] body [$];
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] flip;
        fpc_in_t           beat;
        int                spot;
        flip = 8'($urandom_range(1, 255));
        spot = -1;
        if (flaw == FLAW_SHORT || flaw == FLAW_NOISE) begin
            for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
            // half the time it starts like a real frame
            if ($urandom_range(0, 1)) body[0] = cfg_header;
        end else begin
            body.push_back(cfg_header);
            if (cfg_mode == MODE_CRC) body.push_back(cfg_header);
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            if (cfg_mode == MODE_CRC) begin
                crc = CRC_INIT;
                foreach (body[i]) crc = modbus_fold(crc, body[i]);
                body.push_back(crc[15:8]);
                body.push_back(crc[7:0]);
                body.push_back(cfg_tail);
                body.push_back(cfg_tail);
            end else begin
                sum = '0;
                foreach (body[i]) sum = sum + body[i];
                body.push_back(sum);
                body.push_back(cfg_tail);
            end
            // spoil one byte of the chosen part
            case (flaw)
                FLAW_HEADER: spot = (cfg_mode == MODE_CRC) ? $urandom_range(0, 1) : 0;
                FLAW_TAIL: begin
                    spot = body.size() - 1;
                    if (cfg_mode == MODE_CRC) spot = spot - $urandom_range(0, 1);
                end
                FLAW_CHECK: begin
                    spot = body.size() - 2;
                    if (cfg_mode == MODE_CRC) spot = spot - 1 - $urandom_range(0, 1);
                end
                default: spot = -1;
            endcase
            if (spot >= 0) body[spot] = body[spot] ^ flip;
        end
        foreach (body[i]) begin
            beat.byte_in   = body[i];
            beat.last_byte = (i == body.size() - 1);
            pending_beats.push_back(beat);
        end
    endtask

    // about half well-formed frames with random content, the rest spoiled or noise
    task automatic fill_phase(input int budget);
        int          pick;
        int          len;
        frame_flaw_t flaw;
        while (pending_beats.size() < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) flaw = FLAW_NONE;
            else if (pick < 60) flaw = FLAW_HEADER;
            else if (pick < 70) flaw = FLAW_TAIL;
            else if (pick < 80) flaw = FLAW_CHECK;
            else if (pick < 90) flaw = FLAW_SHORT;
            else flaw = FLAW_NOISE;
            if (flaw == FLAW_SHORT) begin
                len = $urandom_range(1, (cfg_mode == MODE_CRC) ? MIN_LEN_CRC - 1
                                                              : MIN_LEN_SUM - 1);
            end else if (flaw == FLAW_NOISE) begin
                len = $urandom_range(1, 12);
            end else begin
                // mostly short payloads, now and then a long one
                len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, 40);
            end
            queue_frame(flaw, len);
        end
    endtask

    // wait until every beat went in and every verdict came out, then let the
    // pipeline settle before anything touches the registers
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    // one register write, shadow copy follows; spare index changes nothing
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FRAME_MODE:  cfg_mode = val[0];
            CFG_HEADER_CHAR: cfg_header = val;
            CFG_TAIL_CHAR:   cfg_tail = val;
            default: ;
        endcase
    endtask

    // sender: offers the next pending beat, predicts on every accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) track_frame_byte(s_data);
            // a new beat may go up only once the current one is taken
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_beats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus the long hold-off, checks every verdict beat
    always @(posedge aclk) begin
        fpc_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict with none expected, got ok=%0b reason=%0d",
                             $time, m_data.frame_ok, m_data.fail_reason);
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_data.frame_ok !== want.frame_ok) begin
                        $display("%0t: frame_ok expected %0b got %0b",
                                 $time, want.frame_ok, m_data.frame_ok);
                        mismatch_count++;
                    end
                    if (m_data.fail_reason !== want.fail_reason) begin
                        $display("%0t: fail_reason expected %0d got %0d",
                                 $time, want.fail_reason, m_data.fail_reason);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long hold-off on the result side, timed here so the sender keeps going
    initial begin
        wait (hold_go);
        @(negedge aclk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_on = 1'b0;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("framed_packet_checker_unit: mismatch");
            $finish;
        end
    end

    initial begin
        clear_tracker();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset registers: crc mode, '#' header, '*' tail
        queue_frame(FLAW_NONE, 0);     // shortest good frame
        queue_frame(FLAW_SHORT, 5);    // one byte too short
        queue_frame(FLAW_HEADER, 0);
        wait_quiet();

        // directed, sum mode; upper data bits of the mode write are don't-care
        write_reg(CFG_FRAME_MODE, {7'($urandom_range(0, 127)), MODE_SUM});
        @(negedge aclk);
        queue_frame(FLAW_NONE, 0);     // header, checksum, tail only
        queue_frame(FLAW_SHORT, 2);
        queue_frame(FLAW_TAIL, 0);
        wait_quiet();

        // random phases, each with its own registers and idle pattern
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    // no idling, char extremes
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_reg(CFG_FRAME_MODE, {7'd0, MODE_CRC});
                    write_reg(CFG_HEADER_CHAR, 8'h00);
                    write_reg(CFG_TAIL_CHAR, 8'hFF);
                end
                1: begin
                    send_idle_pct = 46; recv_stall_pct = 0;
                    write_reg(CFG_FRAME_MODE, {7'd0, MODE_SUM});
                    write_reg(CFG_HEADER_CHAR, 8'hFF);
                    write_reg(CFG_TAIL_CHAR, 8'h00);
                    write_reg(CFG_SPARE_IDX, 8'($urandom_range(0, 255)));
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 46;
                    write_reg(CFG_FRAME_MODE, {7'd0, MODE_CRC});
                    write_reg(CFG_HEADER_CHAR, 8'($urandom_range(0, 255)));
                    write_reg(CFG_TAIL_CHAR, 8'($urandom_range(0, 255)));
                end
                3: begin
                    send_idle_pct = 15; recv_stall_pct = 15;
                    write_reg(CFG_FRAME_MODE, {7'd0, MODE_SUM});
                    write_reg(CFG_HEADER_CHAR, 8'($urandom_range(0, 255)));
                    write_reg(CFG_TAIL_CHAR, 8'($urandom_range(0, 255)));
                end
                default: begin
                    // pressure: result side held off while beats keep coming,
                    // so a last beat parks at the input and s_ready drops
                    send_idle_pct = 0;  recv_stall_pct = 15;
                    write_reg(CFG_FRAME_MODE, {7'($urandom_range(0, 127)),
                                               1'($urandom_range(0, 1))});
                    write_reg(CFG_HEADER_CHAR, 8'($urandom_range(0, 255)));
                    write_reg(CFG_TAIL_CHAR, 8'($urandom_range(0, 255)));
                    hold_go = 1'b1;
                end
            endcase
            @(negedge aclk);
            fill_phase(PHASE_BEATS);
            wait_quiet();
        end

        if (mismatch_count == 0) begin
            $display("framed_packet_checker_unit: match");
        end else begin
            $display("framed_packet_checker_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fpc_pkg.sv
rtl/core/fpc_frame_track.sv
rtl/core/framed_packet_checker_unit.sv
test/tb_framed_packet_checker_unit.sv
